/* design/wamm_pkg.sv */
// shared constants, field widths, controller state type and sample clamp
// function for the windowed average / min-max tracker; no dependencies
package wamm_pkg;

    localparam int SAMPLE_W       = 7;
    localparam int HELD_W         = 4;
    localparam int SAMPLE_MAX     = 100;
    localparam int WINDOW_DEFAULT = 10;

    localparam logic [SAMPLE_W-1:0] SAMPLE_CAP = SAMPLE_W'(SAMPLE_MAX);
    localparam logic [SAMPLE_W-1:0] LOW_RESET  = SAMPLE_W'(SAMPLE_MAX + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [SAMPLE_W-1:0] v);
        clamp_sample = (v > SAMPLE_CAP) ? SAMPLE_CAP : v;
    endfunction

endpackage

/* design/windowed_average_min_max_tracker_unit.sv */
// top level: windowed temperature/humidity average with lifetime extremes
// depends on wamm_pkg, wamm_ram, wamm_div
//
// usage
//   input channel s_*: one temperature and one humidity sample per transfer,
//   each saturated to 100 before use. result channel m_*: one transfer per
//   input transfer, in order, carrying the floor of each window mean, the
//   lifetime min/max of both channels and the fill count of the window
//   timing
//   an item is taken in ST_IDLE only, so one item is in work at a time. the
//   window slot is read from the ram in the cycle after the transfer, and in that
//   same cycle sums, extremes and the ram write update while the serial
//   divider starts. the divider gives one quotient bit per cycle over
//   SUM_W bits (SUM_W = clog2(WINDOW*100+1), 10 for WINDOW = 10)
//   reset
//   sums, count and slot clear, minima go to 101 and maxima to 0, m_valid
//   drops. window contents are not cleared: a slot's old value is only used once written
//   stall
//   the result register holds while m_ready is low; the next input item is
//   still taken and worked on, and waits in ST_DONE until the register frees
module windowed_average_min_max_tracker_unit #(
    parameter int WINDOW = wamm_pkg::WINDOW_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wamm_pkg::SAMPLE_W-1:0] s_temp_sample,
    input  logic [wamm_pkg::SAMPLE_W-1:0] s_hum_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wamm_pkg::SAMPLE_W-1:0] m_temp_avg,
    output logic [wamm_pkg::SAMPLE_W-1:0] m_hum_avg,
    output logic [wamm_pkg::SAMPLE_W-1:0] m_temp_min,
    output logic [wamm_pkg::SAMPLE_W-1:0] m_temp_max,
    output logic [wamm_pkg::SAMPLE_W-1:0] m_hum_min,
    output logic [wamm_pkg::SAMPLE_W-1:0] m_hum_max,
    output logic [wamm_pkg::HELD_W-1:0]   m_samples_held
);

    localparam int SW    = wamm_pkg::SAMPLE_W;
    localparam int SUM_W = $clog2(WINDOW * wamm_pkg::SAMPLE_MAX + 1);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WINDOW);
    localparam logic [AW:0]      LAST_SLOT  = (AW + 1)'(WINDOW - 1);

    wamm_pkg::state_t state_reg, state_next;

    // control decode
    logic s_xfer, m_xfer, ram_we, div_start, load_out;
    logic div_done;

    // item registers
    logic [SW-1:0]    temp_in_reg, hum_in_reg;
    logic [AW-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [SUM_W-1:0] temp_sum_reg, temp_sum_next, hum_sum_reg, hum_sum_next;
    logic [SW-1:0]    temp_low_reg, temp_low_next, temp_high_reg, temp_high_next;
    logic [SW-1:0]    hum_low_reg, hum_low_next, hum_high_reg, hum_high_next;
    logic             full;

    // window ram, temperature in the upper half of each word
    logic [2*SW-1:0]  ram_rdata;
    logic [SW-1:0]    temp_old, hum_old;

    // divider results
    logic [SUM_W-1:0] temp_quot, hum_quot;

    // result register
    logic             m_valid_reg;
    logic [SW-1:0]    temp_avg_reg, hum_avg_reg;
    logic [SW-1:0]    temp_min_reg, temp_max_reg, hum_min_reg, hum_max_reg;
    logic [wamm_pkg::HELD_W-1:0] held_out_reg;
    logic [CNT_W+wamm_pkg::HELD_W-1:0] held_ext;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid_reg && m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wamm_pkg::ST_IDLE: if (s_valid) state_next = wamm_pkg::ST_READ;
            wamm_pkg::ST_READ: state_next = wamm_pkg::ST_DIV;
            wamm_pkg::ST_DIV:  if (div_done) state_next = wamm_pkg::ST_DONE;
            wamm_pkg::ST_DONE: if (!m_valid_reg || m_ready) state_next = wamm_pkg::ST_IDLE;
            default:           state_next = wamm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            wamm_pkg::ST_IDLE: s_ready = 1'b1;
            wamm_pkg::ST_READ: begin
                ram_we    = 1'b1;
                div_start = 1'b1;
            end
            wamm_pkg::ST_DIV:  ;
            wamm_pkg::ST_DONE: load_out = !m_valid_reg || m_ready;
            default:           ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wamm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // once the window is full, the oldest pair sits in the slot about to be overwritten
    wamm_ram #(
        .WIDTH (2 * SW),
        .DEPTH (WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({temp_in_reg, hum_in_reg}),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign temp_old = ram_rdata[2*SW-1:SW];
    assign hum_old  = ram_rdata[SW-1:0];
    assign full     = (held_reg == FULL_COUNT);

    // window and extreme update, used in ST_READ
    always_comb begin
        held_next     = full ? held_reg : held_reg + 1'b1;
        slot_next     = ({1'b0, slot_reg} == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        temp_sum_next = temp_sum_reg - (full ? SUM_W'(temp_old) : '0) + SUM_W'(temp_in_reg);
        hum_sum_next  = hum_sum_reg - (full ? SUM_W'(hum_old) : '0) + SUM_W'(hum_in_reg);
        temp_low_next  = (temp_in_reg < temp_low_reg)  ? temp_in_reg : temp_low_reg;
        temp_high_next = (temp_in_reg > temp_high_reg) ? temp_in_reg : temp_high_reg;
        hum_low_next   = (hum_in_reg < hum_low_reg)    ? hum_in_reg  : hum_low_reg;
        hum_high_next  = (hum_in_reg > hum_high_reg)   ? hum_in_reg  : hum_high_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            held_reg      <= '0;
            temp_sum_reg  <= '0;
            hum_sum_reg   <= '0;
            temp_low_reg  <= wamm_pkg::LOW_RESET;
            temp_high_reg <= '0;
            hum_low_reg   <= wamm_pkg::LOW_RESET;
            hum_high_reg  <= '0;
        end else if (ram_we) begin
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            temp_sum_reg  <= temp_sum_next;
            hum_sum_reg   <= hum_sum_next;
            temp_low_reg  <= temp_low_next;
            temp_high_reg <= temp_high_next;
            hum_low_reg   <= hum_low_next;
            hum_high_reg  <= hum_high_next;
        end
        // saturate on the way in
        if (s_xfer) begin
            temp_in_reg <= wamm_pkg::clamp_sample(s_temp_sample);
            hum_in_reg  <= wamm_pkg::clamp_sample(s_hum_sample);
        end
    end

    // both means share the divisor, so one serial unit does both
    wamm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .dividend_a (temp_sum_next),
        .dividend_b (hum_sum_next),
        .divisor    (held_next),
        .done       (div_done),
        .quotient_a (temp_quot),
        .quotient_b (hum_quot)
    );

    // count output carries the low bits only
    assign held_ext = {{wamm_pkg::HELD_W{1'b0}}, held_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_xfer) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            temp_avg_reg <= temp_quot[SW-1:0];
            hum_avg_reg  <= hum_quot[SW-1:0];
            temp_min_reg <= temp_low_reg;
            temp_max_reg <= temp_high_reg;
            hum_min_reg  <= hum_low_reg;
            hum_max_reg  <= hum_high_reg;
            held_out_reg <= held_ext[wamm_pkg::HELD_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_temp_avg     = temp_avg_reg;
    assign m_hum_avg      = hum_avg_reg;
    assign m_temp_min     = temp_min_reg;
    assign m_temp_max     = temp_max_reg;
    assign m_hum_min      = hum_min_reg;
    assign m_hum_max      = hum_max_reg;
    assign m_samples_held = held_out_reg;

endmodule

/* design/wamm_ram.sv */
// generic single write port ram with registered read
// no dependencies
module wamm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/wamm_div.sv */
// bit-serial restoring divider, two dividends over one shared divisor,
// one quotient bit per cycle; no dependencies
module wamm_div #(
    parameter int SUM_W = 10,
    parameter int CNT_W = 4,
    localparam int NW   = $clog2(SUM_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend_a,
    input  logic [SUM_W-1:0] dividend_b,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient_a,
    output logic [SUM_W-1:0] quotient_b
);

    logic             busy_reg, busy_next;
    logic [NW-1:0]    count_reg, count_next;
    logic [CNT_W-1:0] divisor_reg;
    logic [SUM_W-1:0] shift_a_reg, shift_a_next, shift_b_reg, shift_b_next;
    logic [CNT_W-1:0] rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [CNT_W:0]   trial_a, trial_b, dvs;
    logic             ge_a, ge_b;

    // shift the next dividend bit into each partial remainder
    assign trial_a = {rem_a_reg, shift_a_reg[SUM_W-1]};
    assign trial_b = {rem_b_reg, shift_b_reg[SUM_W-1]};
    assign dvs     = {1'b0, divisor_reg};
    assign ge_a    = trial_a >= dvs;
    assign ge_b    = trial_b >= dvs;

    always_comb begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        shift_a_next = shift_a_reg;
        shift_b_next = shift_b_reg;
        rem_a_next   = rem_a_reg;
        rem_b_next   = rem_b_reg;
        if (start) begin
            busy_next    = 1'b1;
            count_next   = NW'(SUM_W);
            shift_a_next = dividend_a;
            shift_b_next = dividend_b;
            rem_a_next   = '0;
            rem_b_next   = '0;
        end else if (busy_reg) begin
            count_next   = count_reg - 1'b1;
            busy_next    = (count_reg != NW'(1));
            shift_a_next = {shift_a_reg[SUM_W-2:0], ge_a};
            shift_b_next = {shift_b_reg[SUM_W-2:0], ge_b};
            rem_a_next   = ge_a ? CNT_W'(trial_a - dvs) : trial_a[CNT_W-1:0];
            rem_b_next   = ge_b ? CNT_W'(trial_b - dvs) : trial_b[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
        if (start) begin
            divisor_reg <= divisor;
        end
        shift_a_reg <= shift_a_next;
        shift_b_reg <= shift_b_next;
        rem_a_reg   <= rem_a_next;
        rem_b_reg   <= rem_b_next;
    end

    // last step completes at this edge
    assign done       = busy_reg && (count_reg == NW'(1));
    assign quotient_a = shift_a_reg;
    assign quotient_b = shift_b_reg;

endmodule

/* design/wamm_checker.sv */
// port-level checks for the tracker, attached to the top level by bind
// depends on wamm_pkg and windowed_average_min_max_tracker_unit
module wamm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [wamm_pkg::SAMPLE_W-1:0] m_temp_avg,
    input logic [wamm_pkg::SAMPLE_W-1:0] m_hum_avg,
    input logic [wamm_pkg::SAMPLE_W-1:0] m_temp_min,
    input logic [wamm_pkg::SAMPLE_W-1:0] m_temp_max,
    input logic [wamm_pkg::SAMPLE_W-1:0] m_hum_min,
    input logic [wamm_pkg::SAMPLE_W-1:0] m_hum_max
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // stalled result keeps its averages
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_temp_avg) && $stable(m_hum_avg))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // a window mean lies between the lifetime extremes
    a_temp_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temp_min <= m_temp_avg) && (m_temp_avg <= m_temp_max))
        else $error("temperature mean outside extremes");

    a_hum_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hum_min <= m_hum_avg) && (m_hum_avg <= m_hum_max))
        else $error("humidity mean outside extremes");

endmodule

bind windowed_average_min_max_tracker_unit wamm_checker u_wamm_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_temp_avg (m_temp_avg),
    .m_hum_avg  (m_hum_avg),
    .m_temp_min (m_temp_min),
    .m_temp_max (m_temp_max),
    .m_hum_min  (m_hum_min),
    .m_hum_max  (m_hum_max)
);

/* bench/wamm_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the windowed average / min-max tracker: tracks the window,
// sums and extremes itself and compares every result transfer; needs wamm_pkg
module wamm_result_checker #(
    parameter int WINDOW = wamm_pkg::WINDOW_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [wamm_pkg::SAMPLE_W-1:0] s_temp_sample,
    input  logic [wamm_pkg::SAMPLE_W-1:0] s_hum_sample,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [wamm_pkg::SAMPLE_W-1:0] m_temp_avg,
    input  logic [wamm_pkg::SAMPLE_W-1:0] m_hum_avg,
    input  logic [wamm_pkg::SAMPLE_W-1:0] m_temp_min,
    input  logic [wamm_pkg::SAMPLE_W-1:0] m_temp_max,
    input  logic [wamm_pkg::SAMPLE_W-1:0] m_hum_min,
    input  logic [wamm_pkg::SAMPLE_W-1:0] m_hum_max,
    input  logic [wamm_pkg::HELD_W-1:0]   m_samples_held,
    input  logic                          end_check,
    output int                            errors,
    output int                            outstanding
);
    import wamm_pkg::*;

    localparam int SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int IDX_W = $clog2(WINDOW + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] temp_avg;
        logic [SAMPLE_W-1:0] hum_avg;
        logic [SAMPLE_W-1:0] temp_min;
        logic [SAMPLE_W-1:0] temp_max;
        logic [SAMPLE_W-1:0] hum_min;
        logic [SAMPLE_W-1:0] hum_max;
        logic [HELD_W-1:0]   held;
    } reading_t;

    logic [SAMPLE_W-1:0] temp_ring [WINDOW];
    logic [SAMPLE_W-1:0] hum_ring  [WINDOW];
    logic [IDX_W-1:0]    next_slot;
    logic [IDX_W-1:0]    fill;
    logic [SUM_W-1:0]    temp_total;
    logic [SUM_W-1:0]    hum_total;
    logic [SAMPLE_W-1:0] temp_lo, temp_hi, hum_lo, hum_hi;
    reading_t            pending_readings [$];
    bit                  leftover_flagged;

    initial begin
        errors      = 0;
        outstanding = 0;
    end

    task automatic flag(input string what);
        errors++;
        $display("[%0t] tracker check: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got, want);
        if (got !== want) begin
            flag($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // one sample pair into the window; returns the reading it produces
    function automatic reading_t absorb_pair(input logic [SAMPLE_W-1:0] t_raw, h_raw);
        logic [SAMPLE_W-1:0] t, h;
        reading_t            r;
        t = (t_raw > SAMPLE_CAP) ? SAMPLE_CAP : t_raw;
        h = (h_raw > SAMPLE_CAP) ? SAMPLE_CAP : h_raw;
        if (fill == IDX_W'(WINDOW)) begin
            temp_total = temp_total - SUM_W'(temp_ring[next_slot]);
            hum_total  = hum_total - SUM_W'(hum_ring[next_slot]);
        end else begin
            fill = fill + 1'b1;
        end
        temp_ring[next_slot] = t;
        hum_ring[next_slot]  = h;
        temp_total = temp_total + SUM_W'(t);
        hum_total  = hum_total + SUM_W'(h);
        next_slot  = (next_slot == IDX_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
        if (t < temp_lo) temp_lo = t;
        if (t > temp_hi) temp_hi = t;
        if (h < hum_lo) hum_lo = h;
        if (h > hum_hi) hum_hi = h;
        r.temp_avg = SAMPLE_W'(temp_total / fill);
        r.hum_avg  = SAMPLE_W'(hum_total / fill);
        r.temp_min = temp_lo;
        r.temp_max = temp_hi;
        r.hum_min  = hum_lo;
        r.hum_max  = hum_hi;
        r.held     = HELD_W'(fill);
        return r;
    endfunction

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            next_slot  = '0;
            fill       = '0;
            temp_total = '0;
            hum_total  = '0;
            temp_lo    = LOW_RESET;
            temp_hi    = '0;
            hum_lo     = LOW_RESET;
            hum_hi     = '0;
            pending_readings.delete();
        end else begin
            if (s_valid && s_ready) begin
                pending_readings.push_back(absorb_pair(s_temp_sample, s_hum_sample));
            end
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    flag("result transfer with no item waiting");
                end else begin
                    want = pending_readings.pop_front();
                    compare_field("temp_avg", m_temp_avg, want.temp_avg);
                    compare_field("hum_avg", m_hum_avg, want.hum_avg);
                    compare_field("temp_min", m_temp_min, want.temp_min);
                    compare_field("temp_max", m_temp_max, want.temp_max);
                    compare_field("hum_min", m_hum_min, want.hum_min);
                    compare_field("hum_max", m_hum_max, want.hum_max);
                    compare_field("samples_held", m_samples_held, want.held);
                end
            end
            if (end_check && !leftover_flagged && pending_readings.size() != 0) begin
                flag($sformatf("%0d results never arrived", pending_readings.size()));
                leftover_flagged = 1'b1;
            end
        end
        outstanding <= pending_readings.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// top of the tracker bench: clock, reset, sample stimulus, result back-pressure
// and the verdict; needs wamm_pkg, the tracker unit and wamm_result_checker
module testbench;
    import wamm_pkg::*;

    localparam int WINDOW        = WINDOW_DEFAULT;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int HOLD_AT       = 300;   // item index where the long stall starts
    localparam int DRAIN_AT      = 650;   // item index where the sender waits for all results
    localparam int CALM_ITEMS    = 150;   // closing stretch with no idling at all
    localparam int LONG_HOLD     = 300;   // cycles the receiver stays off
    localparam int SETTLE_CYCLES = 40;    // settling time before the end check
    localparam int DRAIN_LIMIT   = 4000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_temp_sample;
    logic [SAMPLE_W-1:0] s_hum_sample;
    logic                m_valid;
    logic                m_ready;
    logic [SAMPLE_W-1:0] m_temp_avg, m_hum_avg;
    logic [SAMPLE_W-1:0] m_temp_min, m_temp_max;
    logic [SAMPLE_W-1:0] m_hum_min, m_hum_max;
    logic [HELD_W-1:0]   m_samples_held;
    logic                end_check;
    int                  errors;
    int                  outstanding;

    // handshake between the sender and receiver processes
    bit hold_request = 1'b0;
    bit calm         = 1'b0;

    // directed pairs: range ends, saturation just above and far above 100,
    // opposite extremes on the two channels, and enough pairs to wrap the window
    localparam int CORNERS = 22;
    logic [SAMPLE_W-1:0] corner_temp [CORNERS] = '{
        7'd100, 7'd127, 7'd101, 7'd0,   7'd127, 7'd99,  7'd1,   7'd100,
        7'd0,   7'd85,  7'd42,  7'd102, 7'd50,  7'd64,  7'd63,  7'd126,
        7'd2,   7'd100, 7'd0,   7'd127, 7'd55,  7'd100
    };
    logic [SAMPLE_W-1:0] corner_hum [CORNERS] = '{
        7'd100, 7'd127, 7'd101, 7'd127, 7'd0,   7'd1,   7'd99,  7'd0,
        7'd100, 7'd42,  7'd85,  7'd50,  7'd102, 7'd63,  7'd64,  7'd2,
        7'd126, 7'd100, 7'd0,   7'd127, 7'd55,  7'd101
    };

    always #10 aclk = ~aclk;

    windowed_average_min_max_tracker_unit #(
        .WINDOW(WINDOW)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_temp_sample  (s_temp_sample),
        .s_hum_sample   (s_hum_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_temp_avg     (m_temp_avg),
        .m_hum_avg      (m_hum_avg),
        .m_temp_min     (m_temp_min),
        .m_temp_max     (m_temp_max),
        .m_hum_min      (m_hum_min),
        .m_hum_max      (m_hum_max),
        .m_samples_held (m_samples_held)
    );

    wamm_result_checker #(
        .WINDOW(WINDOW)
    ) u_tracker_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_temp_sample  (s_temp_sample),
        .s_hum_sample   (s_hum_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_temp_avg     (m_temp_avg),
        .m_hum_avg      (m_hum_avg),
        .m_temp_min     (m_temp_min),
        .m_temp_max     (m_temp_max),
        .m_hum_min      (m_hum_min),
        .m_hum_max      (m_hum_max),
        .m_samples_held (m_samples_held),
        .end_check      (end_check),
        .errors         (errors),
        .outstanding    (outstanding)
    );

    // sample source: mostly the full 7-bit space so saturation is frequent,
    // some strictly in range, some crowded around the cap
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return SAMPLE_W'($urandom_range(0, 127));
            6, 7:             return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            8:                return SAMPLE_W'($urandom_range(SAMPLE_MAX - 4, 127));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return SAMPLE_CAP;
                    2:       return LOW_RESET;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // offer one pair and hold it until the transfer; returns at the edge that took it,
    // so a following pair can go out in the same step without dropping valid
    task automatic send_pair(input logic [SAMPLE_W-1:0] t, h);
        s_valid       <= 1'b1;
        s_temp_sample <= t;
        s_hum_sample  <= h;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic rest_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // sender stops until every expected result has been taken, or DRAIN_LIMIT runs out
    task automatic wait_drained();
        int waited;
        waited  = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
    endtask

    // random idle burst in front of an item, skipped in the closing stretch
    task automatic maybe_rest();
        if (!calm && $urandom_range(0, 3) == 0) begin
            rest_sender($urandom_range(1, 13));
        end
    endtask

    // stimulus and verdict
    initial begin
        s_valid       <= 1'b0;
        s_temp_sample <= '0;
        s_hum_sample  <= '0;
        aresetn       <= 1'b0;
        end_check     <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: min starts at 101 and max at 0, so the first pair moves all four
        for (int i = 0; i < CORNERS; i++) begin
            maybe_rest();
            send_pair(corner_temp[i], corner_hum[i]);
        end
        wait_drained();

        // random part, with one long receiver stall and one full drain in the middle
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == HOLD_AT) hold_request = 1'b1;
            if (k == DRAIN_AT) wait_drained();
            if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            maybe_rest();
            send_pair(draw_sample(), draw_sample());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // result sink: random stall bursts, one long stall on request, none when calm
    initial begin
        forever begin
            if (hold_request) begin
                // block fills: one result parked, one item in work, input stalls
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* windowed_average_min_max_tracker_unit.f */
design/wamm_pkg.sv
design/wamm_ram.sv
design/wamm_div.sv
design/windowed_average_min_max_tracker_unit.sv
design/wamm_checker.sv
bench/wamm_result_checker.sv
bench/testbench.sv
